// File: hdl/htnm_pkg.sv
// Shared types and constants of the height map to normal map filter.
package htnm_pkg;

	// Default row store depth and the row limit of one frame
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int HEIGHT_LIMIT  = 4096;

	// Register index codes, taken from paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Reset values of the registers
	localparam logic [10:0] WIDTH_RESET  = 11'd1024;
	localparam logic [12:0] HEIGHT_RESET = 13'd1024;

	// 3x3 height window: [row][col], row 0 above, col 0 to the left
	typedef logic [2:0][2:0][7:0] win_t;

	// Status of the normal unit
	typedef struct packed {
		logic busy;
		logic done;
	} nstat_t;

endpackage

// File: hdl/height_to_normal_map_filter.sv
// Top level: row stores, 3x3 window, sequencer, APB registers and output register.
// A sample of row 0 is stored and gives no result; a later sample gives one result,
// two at a row end, none at column 0 of a wider row, from the 28-step square root
// and 8-step divider of the shared normal unit; a drain transaction gives one result.
// Throughput: one height transaction per cycle on row 0; later ones wait on in_stall.
// Reset: asynchronous, active low; clears counters, registers to 1024x1024, no output.
module height_to_normal_map_filter #(
	parameter int MAX_WIDTH = htnm_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  height_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] normal_pixel,
	output logic        end_of_frame,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import htnm_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_DRD  = 6'b000100,
		S_LOAD = 6'b001000,
		S_CALC = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	state_t state_q;
	logic [10:0] image_width_q;
	logic [12:0] image_height_q;
	logic [AW-1:0] column_count_q;
	logic [12:0] row_count_q;
	logic draining_q;
	logic [1:0] rd_cnt_q;
	logic pending_edge_q, sel_edge_q, eof_q;
	logic out_valid_q;
	logic [31:0] normal_pixel_q;
	logic end_of_frame_q;
	win_t window_q;
	logic [7:0] s_q;
	logic [AW-1:0] d_q;

	// Effective image size
	logic [CW-1:0] w_eff;
	logic [AW-1:0] w_last;
	logic [12:0] h_eff;
	always_comb begin
		if (image_width_q == '0) w_eff = CW'(1);
		else if (32'(image_width_q) > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
		else w_eff = CW'(image_width_q);
		w_last = AW'(w_eff - CW'(1));
		if (image_height_q == '0) h_eff = 13'd1;
		else if (image_height_q > 13'(HEIGHT_LIMIT)) h_eff = 13'(HEIGHT_LIMIT);
		else h_eff = image_height_q;
	end

	// Handshakes
	logic in_acc, cfg_wr, out_free, col_last;
	logic [12:0] row_nx;
	assign in_acc   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign cfg_wr   = psel && penable && pwrite;
	assign out_free = !out_valid_q || !out_stall;
	assign col_last = (column_count_q == w_last);
	assign row_nx   = row_count_q + 13'd1;

	// Row stores
	logic up_we, mid_we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0] up_wd, mid_wd, up_rd, mid_rd;
	logic [AW-1:0] d_c2;
	assign d_c2 = (d_q == w_last) ? d_q : d_q + AW'(1);

	always_comb begin
		up_we  = 1'b0;
		mid_we = 1'b0;
		waddr  = column_count_q;
		up_wd  = height_sample;
		mid_wd = height_sample;
		raddr  = column_count_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && !command && !draining_q && row_count_q == '0) begin
					up_we  = 1'b1;
					mid_we = 1'b1;
				end
				if (command && column_count_q != '0) raddr = column_count_q - AW'(1);
			end
			S_READ: begin
				up_we  = 1'b1;
				mid_we = 1'b1;
				up_wd  = mid_rd;
				mid_wd = s_q;
			end
			S_DRD: raddr = (rd_cnt_q == 2'd0) ? d_q : d_c2;
			S_LOAD, S_CALC, S_EMIT: ;
			default: ;
		endcase
	end

	htnm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
		.clk(clk), .we(up_we), .waddr(waddr), .wdata(up_wd), .raddr(raddr), .rdata(up_rd)
	);
	htnm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
		.clk(clk), .we(mid_we), .waddr(waddr), .wdata(mid_wd), .raddr(raddr), .rdata(mid_rd)
	);

	// Normal unit and its window select
	win_t edge_win, nwin;
	logic nstart;
	nstat_t nstat;
	logic [31:0] npixel;
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			edge_win[r][0] = window_q[r][1];
			edge_win[r][1] = window_q[r][2];
			edge_win[r][2] = window_q[r][2];
		end
	end
	assign nwin   = sel_edge_q ? edge_win : window_q;
	assign nstart = (state_q == S_LOAD);

	htnm_normal u_normal (
		.clk(clk), .arst_n(arst_n), .start(nstart), .win(nwin), .stat(nstat), .pixel(npixel)
	);

	// Sequencer, counters, registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
			column_count_q <= '0;
			row_count_q    <= '0;
			draining_q     <= 1'b0;
			rd_cnt_q       <= '0;
			pending_edge_q <= 1'b0;
			sel_edge_q     <= 1'b0;
			eof_q          <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			// output valid: set on emit, cleared once taken
			if (state_q == S_EMIT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && command && draining_q) begin
						state_q        <= S_DRD;
						rd_cnt_q       <= '0;
						pending_edge_q <= 1'b0;
						sel_edge_q     <= 1'b0;
						eof_q          <= col_last;
						if (col_last) begin
							column_count_q <= '0;
							row_count_q    <= '0;
							draining_q     <= 1'b0;
						end else begin
							column_count_q <= column_count_q + AW'(1);
						end
					end else if (in_acc && !command && !draining_q) begin
						if (row_count_q == '0) begin
							if (col_last) begin
								column_count_q <= '0;
								row_count_q    <= row_nx;
								draining_q     <= (row_nx >= h_eff);
							end else begin
								column_count_q <= column_count_q + AW'(1);
							end
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					eof_q <= 1'b0;
					if (col_last) begin
						column_count_q <= '0;
						row_count_q    <= row_nx;
						draining_q     <= (row_nx >= h_eff);
					end else begin
						column_count_q <= column_count_q + AW'(1);
					end
					if (column_count_q != '0) begin
						sel_edge_q     <= 1'b0;
						pending_edge_q <= col_last;
						state_q        <= S_LOAD;
					end else if (col_last) begin
						sel_edge_q     <= 1'b1;
						pending_edge_q <= 1'b0;
						state_q        <= S_LOAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DRD: begin
					rd_cnt_q <= rd_cnt_q + 2'd1;
					if (rd_cnt_q == 2'd2) state_q <= S_LOAD;
				end
				S_LOAD: state_q <= S_CALC;
				S_CALC: begin
					if (nstat.done) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (pending_edge_q) begin
							pending_edge_q <= 1'b0;
							sel_edge_q     <= 1'b1;
							state_q        <= S_LOAD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// any register write restarts the frame
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_WIDTH:  image_width_q  <= pwdata[10:0];
					REG_HEIGHT: image_height_q <= pwdata[12:0];
					default: ;
				endcase
				column_count_q <= '0;
				row_count_q    <= '0;
				draining_q     <= 1'b0;
			end
		end
	end

	// Window and payload registers
	always_ff @(posedge clk) begin
		if (in_acc && state_q == S_IDLE) begin
			s_q <= height_sample;
			d_q <= column_count_q;
		end
		if (state_q == S_READ) begin
			for (int r = 0; r < 3; r++) begin
				logic [7:0] cv;
				cv = (r == 0) ? up_rd : ((r == 1) ? mid_rd : s_q);
				if (column_count_q == '0) begin
					window_q[r][0] <= cv;
					window_q[r][1] <= cv;
					window_q[r][2] <= cv;
				end else begin
					window_q[r][0] <= window_q[r][1];
					window_q[r][1] <= window_q[r][2];
					window_q[r][2] <= cv;
				end
			end
		end
		if (state_q == S_DRD) begin
			window_q[0][rd_cnt_q] <= up_rd;
			window_q[1][rd_cnt_q] <= mid_rd;
			window_q[2][rd_cnt_q] <= mid_rd;
		end
		if (state_q == S_EMIT && out_free) begin
			normal_pixel_q <= npixel;
			end_of_frame_q <= eof_q;
		end
	end

	// Register read back
	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = {21'd0, image_width_q};
			REG_HEIGHT: prdata = {19'd0, image_height_q};
			default:    prdata = '0;
		endcase
	end

	assign pready       = 1'b1;
	assign out_valid    = out_valid_q;
	assign normal_pixel = normal_pixel_q;
	assign end_of_frame = end_of_frame_q;

	// Checks
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		column_count_q <= w_last)
		else $error("column count beyond row width");
	a_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !nstat.busy)
		else $error("normal unit busy while sequencer idle");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		nstart |-> !nstat.busy)
		else $error("window loaded while normal unit busy");
	a_eof_single: assert property (@(posedge clk) disable iff (!arst_n)
		eof_q |-> !pending_edge_q && !sel_edge_q)
		else $error("end of frame on a row end result");

endmodule

// File: hdl/htnm_ram.sv
// Generic simple dual port RAM with registered read data.
module htnm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/htnm_normal.sv
// Iterative normal unit: vector, squares, bit-serial square root, 8-step divide.
module htnm_normal (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  htnm_pkg::win_t  win,
	output htnm_pkg::nstat_t stat,
	output logic [31:0]     pixel
);
	import htnm_pkg::*;

	localparam logic signed [16:0] INV_SQRT2 = 17'sd46341;
	localparam logic [27:0] VZ = 28'd167116800;
	localparam logic [55:0] VZ2 = 56'(VZ) * 56'(VZ);
	localparam int ROOT_STEPS = 28;
	localparam int DIV_STEPS = 8;

	typedef enum logic [4:0] {
		P_IDLE = 5'b00001,
		P_SQ   = 5'b00010,
		P_SUM  = 5'b00100,
		P_ROOT = 5'b01000,
		P_DIV  = 5'b10000
	} phase_t;

	phase_t phase_q;
	logic [4:0] cnt_q;
	logic prep_q;
	logic done_q;
	logic signed [27:0] vx_q, vy_q;
	logic [53:0] sqx_q, sqy_q;
	logic [55:0] rad_q;
	logic [31:0] rem_q;
	logic [27:0] root_q;
	logic [28:0] dvs_q;
	logic [36:0] num_q [3];
	logic [7:0]  quo_q [3];
	logic [31:0] pixel_q;

	// Vector from the window; the centre cancels out
	logic signed [8:0]  ax, ay;
	logic signed [10:0] dx, dy;
	logic signed [27:0] vx, vy;
	always_comb begin
		ax = $signed({1'b0, win[1][0]}) - $signed({1'b0, win[1][2]});
		ay = $signed({1'b0, win[0][1]}) - $signed({1'b0, win[2][1]});
		dx = 11'(signed'({3'b0, win[0][0]})) + 11'(signed'({3'b0, win[2][0]}))
			- 11'(signed'({3'b0, win[0][2]})) - 11'(signed'({3'b0, win[2][2]}));
		dy = 11'(signed'({3'b0, win[0][0]})) + 11'(signed'({3'b0, win[0][2]}))
			- 11'(signed'({3'b0, win[2][0]})) - 11'(signed'({3'b0, win[2][2]}));
		// diagonal products need 26 bits, so widen before multiplying
		vx = (28'(ax) <<< 16) + (28'(dx) * 28'(INV_SQRT2));
		vy = (28'(ay) <<< 16) + (28'(dy) * 28'(INV_SQRT2));
	end

	// Magnitudes for squaring
	logic [26:0] ux, uy;
	assign ux = vx_q[27] ? 27'(-vx_q) : 27'(vx_q);
	assign uy = vy_q[27] ? 27'(-vy_q) : 27'(vy_q);

	// One square root step: two radicand bits
	logic [31:0] rem_sh, trial;
	logic        root_ge;
	assign rem_sh  = {rem_q[29:0], rad_q[55:54]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign root_ge = (rem_sh >= trial);

	// Divide setup: numerator 255*(c+L), divisor 2L
	logic signed [29:0] csum [3];
	logic [28:0] cpos [3];
	logic [36:0] num_init [3];
	always_comb begin
		csum[0] = $signed({2'b00, root_q}) + 30'(vx_q);
		csum[1] = $signed({2'b00, root_q}) + 30'(vy_q);
		csum[2] = $signed({2'b00, root_q}) + $signed({2'b00, VZ});
		for (int i = 0; i < 3; i++) begin
			cpos[i] = csum[i][28:0];
			num_init[i] = {cpos[i], 8'd0} - 37'(cpos[i]);
		end
	end

	// One quotient bit per component
	logic [36:0] dtrial;
	logic [36:0] num_nx [3];
	logic [7:0]  quo_nx [3];
	always_comb begin
		dtrial = 37'(dvs_q) << cnt_q[2:0];
		for (int i = 0; i < 3; i++) begin
			num_nx[i] = num_q[i];
			quo_nx[i] = quo_q[i];
			if (num_q[i] >= dtrial) begin
				num_nx[i] = num_q[i] - dtrial;
				quo_nx[i][cnt_q[2:0]] = 1'b1;
			end
		end
	end

	// Phase sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
			prep_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (start) phase_q <= P_SQ;
				end
				P_SQ: phase_q <= P_SUM;
				P_SUM: begin
					phase_q <= P_ROOT;
					cnt_q   <= '0;
				end
				P_ROOT: begin
					if (cnt_q == 5'(ROOT_STEPS - 1)) begin
						phase_q <= P_DIV;
						cnt_q   <= 5'(DIV_STEPS - 1);
						prep_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				P_DIV: begin
					if (prep_q) begin
						prep_q <= 1'b0;
					end else if (cnt_q == '0) begin
						phase_q <= P_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (phase_q)
			P_IDLE: begin
				if (start) begin
					vx_q <= vx;
					vy_q <= vy;
				end
			end
			P_SQ: begin
				sqx_q <= ux * ux;
				sqy_q <= uy * uy;
			end
			P_SUM: begin
				rad_q  <= 56'(sqx_q) + 56'(sqy_q) + VZ2;
				rem_q  <= '0;
				root_q <= '0;
			end
			P_ROOT: begin
				rad_q <= {rad_q[53:0], 2'b00};
				if (root_ge) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[26:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[26:0], 1'b0};
				end
			end
			P_DIV: begin
				if (prep_q) begin
					dvs_q <= {root_q, 1'b0};
					for (int i = 0; i < 3; i++) begin
						num_q[i] <= num_init[i];
						quo_q[i] <= '0;
					end
				end else begin
					for (int i = 0; i < 3; i++) begin
						num_q[i] <= num_nx[i];
						quo_q[i] <= quo_nx[i];
					end
					if (cnt_q == '0) begin
						pixel_q <= {quo_nx[0], quo_nx[1], quo_nx[2], 8'hFF};
					end
				end
			end
			default: ;
		endcase
	end

	assign stat.busy = (phase_q != P_IDLE);
	assign stat.done = done_q;
	assign pixel     = pixel_q;

	// Checks
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> phase_q == P_IDLE)
		else $error("normal unit started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> phase_q == P_IDLE && !prep_q)
		else $error("done while still working");
	a_root_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == P_ROOT |-> cnt_q < 5'(ROOT_STEPS))
		else $error("root step count out of range");

endmodule
